@@ rtl/dpq_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the dithered PCM quantizer.
package dpq_pkg;

  typedef enum logic [1:0] {
    FMT_U8  = 2'd0,
    FMT_S16 = 2'd1,
    FMT_S24 = 2'd2,
    FMT_S32 = 2'd3
  } fmt_e;

  typedef enum logic {
    REG_OUT_FORMAT   = 1'b0,
    REG_DITHER_LEVEL = 1'b1
  } reg_idx_e;

  localparam int unsigned SampleW = 34;
  localparam int unsigned WordW   = 32;
  localparam int unsigned LevelW  = 16;
  localparam int unsigned NoiseW  = 32;
  localparam int unsigned DithW   = LevelW + 1 + NoiseW + 1;
  localparam int unsigned FracW   = 48;
  localparam int unsigned SumW    = 75;
  localparam int unsigned IntW    = SumW - FracW;

  localparam fmt_e                FmtReset   = FMT_S16;
  localparam logic [LevelW-1:0]   LevelReset = 16'h8000;
  localparam logic [NoiseW-1:0]   SeedReset  = 32'h1234_5678;

endpackage

@@ rtl/dithered_pcm_quantizer_top.sv @@
`timescale 1ns / 1ps
// Top level of the dithered PCM quantizer: four-stage pipeline from sample to PCM word.
//
// Input words carry a signed Q3.31 sample and a block-start flag on a valid/ready
// channel; each gives exactly one PCM word on the output valid/ready channel.
// The output format and the dither level are set through a plain write port and
// should only be changed while no words are in flight.
// An accepted word passes the stage-one, stage-two, stage-three and output registers.
// One word per cycle is sustained while the receiver is ready: the xorshift step
// happens at acceptance (except in the 32-bit format), the 17x33 dither multiply
// has its own stage, the 75-bit exact sum its own, and rounding, clamping and
// encoding fill the output register.
// Each stage holds its word while the stage after it is full and cannot move on,
// so a stalled receiver backs the pipeline up one stage at a time; up to four
// words are held before the input ready drops.
// Reset empties the pipeline, seeds the generator with 0x12345678, clears the
// previous noise term and selects 16-bit output with unity dither level.
module dithered_pcm_quantizer_top
  import dpq_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [LevelW-1:0]         cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic                      block_start_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [WordW-1:0]          pcm_word_o
);

  fmt_e              fmt_q;
  logic [LevelW-1:0] level_q;
  logic [NoiseW-1:0] gen_q, gen_d;
  logic [NoiseW-1:0] prev_q, prev_d;

  logic s1_vld_q, s2_vld_q, s3_vld_q, out_vld_q;
  logic rdy1, rdy2, rdy3, rdy4;

  logic signed [SampleW-1:0] s1_sample_q, s2_sample_q, s3_sample_q;
  logic [NoiseW-1:0]         s1_g_q, s1_prev_q;
  logic signed [DithW-1:0]   s2_dith_q;
  logic signed [SumW-1:0]    s3_sum_q;
  logic [WordW-1:0]          word_q;

  logic [NoiseW-1:0]       g1, g2, g3, prev_eff;
  logic signed [NoiseW:0]  noise_sum;
  logic signed [DithW-1:0] dith;
  logic signed [SumW-1:0]  s_scaled, sum;
  logic [IntW-1:0]         y_floor;
  logic [FracW-1:0]        frac;
  logic                    round_up;
  logic signed [IntW:0]    y_r;
  logic                    neg, ok8, ok16, ok24, ok32;
  logic [WordW-1:0]        word_d;
  logic                    accept;

  assign rdy4       = !out_vld_q || out_ready_i;
  assign rdy3       = !s3_vld_q || rdy4;
  assign rdy2       = !s2_vld_q || rdy3;
  assign rdy1       = !s1_vld_q || rdy2;
  assign in_ready_o = rdy1;
  assign accept     = in_valid_i && rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q   <= FmtReset;
      level_q <= LevelReset;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_OUT_FORMAT:   fmt_q   <= fmt_e'(cfg_data_i[1:0]);
        REG_DITHER_LEVEL: level_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Generator step; the 32-bit format leaves the generator untouched.
  always_comb begin
    g1       = gen_q ^ (gen_q << 13);
    g2       = g1 ^ (g1 >> 17);
    g3       = g2 ^ (g2 << 5);
    prev_eff = block_start_i ? '0 : prev_q;
    gen_d    = gen_q;
    prev_d   = prev_q;
    if (accept) begin
      if (fmt_q == FMT_S32) begin
        prev_d = prev_eff;
      end else begin
        gen_d  = g3;
        prev_d = g3;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q     <= SeedReset;
      prev_q    <= '0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      gen_q  <= gen_d;
      prev_q <= prev_d;
      if (rdy1) s1_vld_q  <= in_valid_i;
      if (rdy2) s2_vld_q  <= s1_vld_q;
      if (rdy3) s3_vld_q  <= s2_vld_q;
      if (rdy4) out_vld_q <= s3_vld_q;
    end
  end

  // The dither is level * (cur + prev) in units of 2^-48 output LSB.
  assign noise_sum = $signed({s1_g_q[NoiseW-1], s1_g_q})
                   + $signed({s1_prev_q[NoiseW-1], s1_prev_q});
  assign dith      = $signed({1'b0, level_q}) * noise_sum;

  always_comb begin
    case (fmt_q)
      FMT_U8:  s_scaled = {{17{s2_sample_q[SampleW-1]}}, s2_sample_q, 24'b0};
      FMT_S24: s_scaled = {s2_sample_q[SampleW-1], s2_sample_q, 40'b0};
      default: s_scaled = {{9{s2_sample_q[SampleW-1]}}, s2_sample_q, 32'b0};
    endcase
    sum = s_scaled + {{(SumW - DithW){s2_dith_q[DithW-1]}}, s2_dith_q};
  end

  // Round to nearest with ties to even, then clamp and encode; the 32-bit format only clamps the sample.
  always_comb begin
    y_floor  = s3_sum_q[SumW-1:FracW];
    frac     = s3_sum_q[FracW-1:0];
    round_up = frac[FracW-1] && ((|frac[FracW-2:0]) || y_floor[0]);
    y_r      = $signed({y_floor[IntW-1], y_floor}) + $signed({{IntW{1'b0}}, round_up});
    neg      = y_r[IntW];
    ok8      = (&y_r[IntW:7])  || !(|y_r[IntW:7]);
    ok16     = (&y_r[IntW:15]) || !(|y_r[IntW:15]);
    ok24     = (&y_r[IntW:23]) || !(|y_r[IntW:23]);
    ok32     = (&s3_sample_q[SampleW-1:31]) || !(|s3_sample_q[SampleW-1:31]);
    case (fmt_q)
      FMT_U8: begin
        if (ok8) word_d = {24'b0, ~y_r[7], y_r[6:0]};
        else     word_d = neg ? 32'h0000_0000 : 32'h0000_00FF;
      end
      FMT_S16: begin
        if (ok16) word_d = {16'b0, y_r[15:0]};
        else      word_d = neg ? 32'h0000_8000 : 32'h0000_7FFF;
      end
      FMT_S24: begin
        if (ok24) word_d = {8'b0, y_r[23:0]};
        else      word_d = neg ? 32'h0080_0000 : 32'h007F_FFFF;
      end
      default: begin
        if (ok32) word_d = s3_sample_q[WordW-1:0];
        else      word_d = s3_sample_q[SampleW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sample_q <= sample_i;
      s1_g_q      <= g3;
      s1_prev_q   <= prev_eff;
    end
    if (rdy2 && s1_vld_q) begin
      s2_sample_q <= s1_sample_q;
      s2_dith_q   <= dith;
    end
    if (rdy3 && s2_vld_q) begin
      s3_sample_q <= s2_sample_q;
      s3_sum_q    <= sum;
    end
    if (rdy4 && s3_vld_q) begin
      word_q <= word_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign pcm_word_o  = word_q;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the dithered PCM quantizer top level.
module testbench;
  import dpq_pkg::*;

  class PcmScoreboard;
    fmt_e                fmt;
    logic [LevelW-1:0]   level;
    logic [NoiseW-1:0]   gen;
    logic [NoiseW-1:0]   prev;
    logic [WordW-1:0]    expected_q[$];
    int                  mismatches;
    int                  checked;
    int                  per_fmt[4];

    function new();
      fmt = FmtReset;
      level = LevelReset;
      gen = SeedReset;
      prev = '0;
      mismatches = 0;
      checked = 0;
      foreach (per_fmt[i]) per_fmt[i] = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [LevelW-1:0] data);
      if (idx == REG_OUT_FORMAT) begin
        fmt = fmt_e'(data[1:0]);
      end else begin
        level = data;
      end
    endfunction

    function logic [WordW-1:0] quantize(logic signed [SampleW-1:0] smp, logic bs);
      int k;
      int f;
      longint sv;
      longint lv;
      longint gs;
      longint ps;
      longint d;
      longint lo;
      longint hi;
      longint yc;
      logic signed [79:0] sx;
      logic signed [79:0] dx;
      logic signed [79:0] acc;
      logic signed [79:0] yv;
      logic [47:0] frac;
      logic [NoiseW-1:0] g;
      if (bs) prev = '0;
      sv = smp;
      if (fmt == FMT_S32) begin
        if (sv > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (sv < -64'sd2147483648) return 32'h8000_0000;
        return smp[31:0];
      end
      case (fmt)
        FMT_U8: k = 7;
        FMT_S16: k = 15;
        default: k = 23;
      endcase
      f = 31 - k;
      g = gen;
      g ^= g << 13;
      g ^= g >> 17;
      g ^= g << 5;
      gen = g;
      lv = level;
      gs = $signed(g);
      ps = $signed(prev);
      d = lv * (gs + ps);
      prev = g;
      sx = smp;
      dx = d;
      acc = (sx <<< (48 - f)) + dx;
      yv = acc >>> 48;
      frac = acc[47:0];
      if (frac > 48'h8000_0000_0000 || (frac == 48'h8000_0000_0000 && yv[0])) yv = yv + 1;
      lo = -(64'sd1 <<< k);
      hi = (64'sd1 <<< k) - 1;
      if (yv < lo) begin
        yc = lo;
      end else if (yv > hi) begin
        yc = hi;
      end else begin
        yc = longint'(yv);
      end
      case (fmt)
        FMT_U8: return {24'd0, 8'(yc + 128)};
        FMT_S16: return {16'd0, 16'(yc)};
        default: return {8'd0, 24'(yc)};
      endcase
    endfunction

    function void note_sample(logic signed [SampleW-1:0] smp, logic bs);
      per_fmt[fmt]++;
      expected_q.push_back(quantize(smp, bs));
    endfunction

    function void check_word(logic [WordW-1:0] got);
      logic [WordW-1:0] want;
      if (expected_q.size() == 0) begin
        if (mismatches < 10) $display("ERROR: unexpected PCM word %h", got);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got !== want) begin
        if (mismatches < 10) begin
          $display("ERROR: PCM word %0d: expected %h, got %h", checked, want, got);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic                      cfg_idx_i;
  logic [LevelW-1:0]         cfg_data_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic signed [SampleW-1:0] sample_i;
  logic                      block_start_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic [WordW-1:0]          pcm_word_o;

  PcmScoreboard sb;
  int src_idle;
  int dst_idle;
  int accepted;
  int block_starts;

  dithered_pcm_quantizer_top uut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .sample_i,
    .block_start_i,
    .out_valid_o,
    .out_ready_i,
    .pcm_word_o
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= dst_idle);
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      sb.note_sample(sample_i, block_start_i);
      accepted++;
      if (block_start_i) block_starts++;
    end
    if (rst_ni && out_valid_o && out_ready_i) sb.check_word(pcm_word_o);
  end

  task automatic send_word(logic signed [SampleW-1:0] s, logic bs);
    while ($urandom_range(0, 99) < src_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= s;
    block_start_i <= bs;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_regs(fmt_e fmt, logic [LevelW-1:0] level);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_OUT_FORMAT;
    cfg_data_i <= {14'($urandom), fmt};
    sb.set_reg(REG_OUT_FORMAT, {14'd0, fmt});
    @(posedge clk_i);
    cfg_idx_i <= REG_DITHER_LEVEL;
    cfg_data_i <= level;
    sb.set_reg(REG_DITHER_LEVEL, level);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [SampleW-1:0] rand_sample(fmt_e fmt);
    logic signed [SampleW-1:0] s;
    logic signed [SampleW-1:0] base;
    int f;
    int mode;
    case (fmt)
      FMT_U8: f = 24;
      FMT_S16: f = 16;
      default: f = 8;
    endcase
    mode = $urandom_range(0, 9);
    case (mode)
      6: s = {2'($urandom_range(0, 3)), 32'($urandom)};
      7: begin
        s = 34'sh0_8000_0000 + 34'($urandom_range(0, 600)) - 34'sd300;
        if ($urandom_range(0, 1)) s = -s;
      end
      8: begin
        base = $signed(16'($urandom));
        s = (base <<< f) | (34'sd1 <<< (f - 1));
        s = s + 34'($urandom_range(0, 2)) - 34'sd1;
      end
      9: s = 34'($urandom_range(0, 511)) - 34'sd256;
      default: s = $signed(32'($urandom));
    endcase
    return s;
  endfunction

  initial begin
    #5ms;
    $display("dithered_pcm_quantizer_top regression: fail");
    $finish;
  end

  initial begin
    fmt_e fmt;
    logic [LevelW-1:0] level;
    int sel;
    sb = new();
    src_idle = 0;
    dst_idle = 0;
    accepted = 0;
    block_starts = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_OUT_FORMAT;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    sample_i = '0;
    block_start_i = 1'b0;
    out_ready_i = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words under the reset settings, then ties, extremes and the 32-bit path.
    src_idle = 14;
    dst_idle = 61;
    send_word(34'sd0, 1'b1);
    send_word(34'sh1_FFFF_FFFF, 1'b0);
    send_word(-34'sh2_0000_0000, 1'b0);
    send_word(34'sh0_7FFF_FFFF, 1'b0);
    send_word(-34'sh0_8000_0000, 1'b0);
    send_word(34'sd12345, 1'b0);
    send_word(-34'sd1, 1'b1);
    drain();
    write_regs(FMT_S16, 16'd0);
    send_word(34'sh0_0000_8000, 1'b0);
    send_word(34'sh0_0001_8000, 1'b0);
    send_word(-34'sh0_0000_8000, 1'b0);
    send_word(34'sh0_0000_8001, 1'b0);
    drain();
    write_regs(FMT_U8, 16'hFFFF);
    send_word(-34'sh2_0000_0000, 1'b0);
    send_word(34'sh1_FFFF_FFFF, 1'b0);
    send_word(34'sd0, 1'b1);
    drain();
    write_regs(FMT_S24, 16'hFFFF);
    send_word(34'sd0, 1'b1);
    send_word(34'sh1_FFFF_FFFF, 1'b0);
    send_word(-34'sh2_0000_0000, 1'b0);
    drain();
    write_regs(FMT_S32, 16'hFFFF);
    send_word(34'sh1_FFFF_FFFF, 1'b0);
    send_word(-34'sh2_0000_0000, 1'b0);
    send_word(34'sh0_7FFF_FFFF, 1'b0);
    send_word(-34'sh0_8000_0000, 1'b0);
    send_word(-34'sd5, 1'b1);
    drain();
    write_regs(FMT_S16, LevelReset);
    send_word(34'sd777, 1'b0);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      src_idle = (ph == 0) ? 14 : (ph == 1) ? 61 : 0;
      dst_idle = (ph == 0) ? 61 : (ph == 1) ? 14 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        fmt = fmt_e'((seg + ph) % 4);
        sel = (seg * 3 + ph) % 4;
        case (sel)
          0: level = 16'd0;
          1: level = 16'hFFFF;
          2: level = 16'($urandom);
          default: level = LevelReset;
        endcase
        write_regs(fmt, level);
        for (int n = 0; n < 86; n++) begin
          send_word(rand_sample(fmt), ($urandom_range(0, 15) == 0));
        end
        drain();
      end
    end

    $display("Run covered %0d input words (%0d block starts) and %0d checked PCM words.",
             accepted, block_starts, sb.checked);
    $display("Words per format: 8-bit %0d, 16-bit %0d, 24-bit %0d, 32-bit %0d.",
             sb.per_fmt[0], sb.per_fmt[1], sb.per_fmt[2], sb.per_fmt[3]);
    if (sb.expected_q.size() != 0) begin
      $display("ERROR: %0d expected PCM words never arrived", sb.expected_q.size());
    end
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("dithered_pcm_quantizer_top regression: pass");
    end else begin
      $display("dithered_pcm_quantizer_top regression: fail");
    end
    $finish;
  end

endmodule
